// ----- rtl/sfl_pkg.sv -----
// Shared types and constants for the separable line filter.
package sfl_pkg;

   localparam int NUM_CH     = 3;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int NUM_COEF   = 7;
   localparam int CENTER_TAP = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int FILL_W     = 3;
   localparam int PROD_W     = COEF_W + PIX_W + 1;
   localparam int ACC_W      = PROD_W + 2;

   localparam logic [FILL_W-1:0] FILL_MAX = '1;

   // Tap weights after reset: unit gain on the centre tap only.
   localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
      16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0
   };

   // Channel 0 is red, 1 green, 2 blue.
   typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_type;

   typedef struct packed {
      logic [PIX_W-1:0] in_red;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_blue;
      logic             end_of_line;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             last_of_line;
   } rsp_payload_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

// ----- rtl/separable_fir_line_filter.sv -----
// The pixel completing a result word goes through the window, product and result registers.
// Throughput: one pixel word per cycle while the output does not stall; after an end-of-line
// word the input holds off while the right border is replicated, one step per unstalled cycle.
// Rate is set by the window step feeding a window, product, sum/saturate pipeline.
// Reset: clears line position, flush and pipeline valid state; taps return to unit centre gain.
// The pixel window needs no clearing: the first pixel of each line fills it.
module separable_fir_line_filter #(
   parameter int TAP_COUNT      = 7,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sfl_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sfl_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_we,
   input  logic [sfl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sfl_pkg::COEF_W-1:0]          csr_wdata
);

   localparam int HALF_RAW   = (TAP_COUNT - 1) / 2;
   localparam int HALF       = (HALF_RAW < 1) ? 1 : ((HALF_RAW > 3) ? 3 : HALF_RAW);
   localparam int WIN        = 2 * HALF + 1;
   localparam int COEF_FIRST = sfl_pkg::CENTER_TAP - HALF;

   logic signed [sfl_pkg::COEF_W-1:0] coef_ff [sfl_pkg::NUM_COEF];
   sfl_pkg::pix_type                  win [WIN];
   sfl_pkg::stage_ctl_type            win_ctl, mult_ctl;
   logic                              win_ready, mult_ready, flush_busy;
   logic signed [sfl_pkg::PROD_W-1:0] prod [sfl_pkg::NUM_CH][WIN];

   // tap registers; writes past the last tap are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfl_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= sfl_pkg::COEF_RESET[i];
         end
      end else if (csr_we && (int'(csr_index) < sfl_pkg::NUM_COEF)) begin
         coef_ff[csr_index] <= $signed(csr_wdata);
      end
   end

   sfl_window #(
      .HALF (HALF),
      .WIN  (WIN)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .win_ready   (win_ready),
      .win         (win),
      .win_ctl     (win_ctl),
      .flush_busy  (flush_busy)
   );

   sfl_tap_mult #(
      .WIN        (WIN),
      .COEF_FIRST (COEF_FIRST)
   ) u_tap_mult (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .coef      (coef_ff),
      .in_ctl    (win_ctl),
      .in_ready  (win_ready),
      .out_ready (mult_ready),
      .prod      (prod),
      .out_ctl   (mult_ctl)
   );

   sfl_sum_sat #(
      .WIN  (WIN),
      .FRAC (COEF_FRAC_BITS)
   ) u_sum_sat (
      .clock       (clock),
      .reset       (reset),
      .prod        (prod),
      .in_ctl      (mult_ctl),
      .in_ready    (mult_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // an end-of-line word always starts a flush that holds off the next word
   a_eol_holds_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.end_of_line) |=> !req_ready)
      else $error("input taken straight after end of line");

   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      flush_busy |-> !req_ready)
      else $error("input ready during border flush");

   // a full, stalled pipeline must push back on the input
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && mult_ctl.valid && win_ctl.valid) |-> !req_ready)
      else $error("input ready while every stage is full and stalled");

endmodule

// ----- rtl/sfl_window.sv -----
// Pixel window with border replication and end-of-line flush sequencing.
module sfl_window #(
   parameter int HALF = 3,
   parameter int WIN  = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sfl_pkg::req_payload_type req_payload,
   input  logic                     win_ready,
   output sfl_pkg::pix_type         win [WIN],
   output sfl_pkg::stage_ctl_type   win_ctl,
   output logic                     flush_busy
);

   localparam int FLUSH_W = (HALF > 1) ? $clog2(HALF + 1) : 1;
   localparam logic [FLUSH_W-1:0] FLUSH_LEN = FLUSH_W'(HALF);
   localparam logic [FLUSH_W-1:0] FLUSH_ONE = FLUSH_W'(1);
   localparam logic [sfl_pkg::FILL_W-1:0] HALF_CNT = sfl_pkg::FILL_W'(HALF);

   sfl_pkg::pix_type              win_ff [WIN];
   sfl_pkg::pix_type              win_in [WIN];
   logic [sfl_pkg::FILL_W-1:0]    fill_ff, fill_in, fill_inc;
   logic [FLUSH_W-1:0]            flush_ff, flush_in;
   sfl_pkg::stage_ctl_type        ctl_ff, ctl_in;
   sfl_pkg::pix_type              new_px, push_px;
   logic                          step_ok, flushing, take;

   always_comb begin
      step_ok   = !ctl_ff.valid || win_ready;
      flushing  = (flush_ff != '0);
      req_ready = step_ok && !flushing;
      take      = req_valid && req_ready;
      fill_inc  = (fill_ff == sfl_pkg::FILL_MAX) ? fill_ff : fill_ff + 1'b1;
      new_px[0] = req_payload.in_red;
      new_px[1] = req_payload.in_green;
      new_px[2] = req_payload.in_blue;
      // during the flush the last pixel of the line is pushed again
      push_px   = flushing ? win_ff[WIN-1] : new_px;

      win_in   = win_ff;
      fill_in  = fill_ff;
      flush_in = flush_ff;
      ctl_in   = ctl_ff;
      if (step_ok) begin
         ctl_in = '0;
      end
      if (take || (flushing && step_ok)) begin
         if (!flushing && (fill_ff == '0)) begin
            // first pixel of a line fills the whole window
            for (int j = 0; j < WIN; j++) begin
               win_in[j] = push_px;
            end
         end else begin
            for (int j = 0; j < WIN - 1; j++) begin
               win_in[j] = win_ff[j+1];
            end
            win_in[WIN-1] = push_px;
         end
         ctl_in.valid = (fill_inc > HALF_CNT);
         ctl_in.last  = flushing && (flush_ff == FLUSH_ONE);
         fill_in      = fill_inc;
         if (flushing) begin
            flush_in = flush_ff - FLUSH_ONE;
            if (flush_ff == FLUSH_ONE) begin
               fill_in = '0;
            end
         end else if (req_payload.end_of_line) begin
            flush_in = FLUSH_LEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         flush_ff <= '0;
         ctl_ff   <= '0;
      end else begin
         fill_ff  <= fill_in;
         flush_ff <= flush_in;
         ctl_ff   <= ctl_in;
      end
   end

   assign win        = win_ff;
   assign win_ctl    = ctl_ff;
   assign flush_busy = flushing;

endmodule

// ----- rtl/sfl_tap_mult.sv -----
// Tap products for all channels of the window, registered.
module sfl_tap_mult #(
   parameter int WIN        = 7,
   parameter int COEF_FIRST = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sfl_pkg::pix_type                     win [WIN],
   input  logic signed [sfl_pkg::COEF_W-1:0]    coef [sfl_pkg::NUM_COEF],
   input  sfl_pkg::stage_ctl_type               in_ctl,
   output logic                                 in_ready,
   input  logic                                 out_ready,
   output logic signed [sfl_pkg::PROD_W-1:0]    prod [sfl_pkg::NUM_CH][WIN],
   output sfl_pkg::stage_ctl_type               out_ctl
);

   localparam int PROD_W = sfl_pkg::PROD_W;

   logic signed [PROD_W-1:0] prod_ff [sfl_pkg::NUM_CH][WIN];
   logic signed [PROD_W-1:0] prod_in [sfl_pkg::NUM_CH][WIN];
   sfl_pkg::stage_ctl_type   ctl_ff;

   always_comb begin
      in_ready = !ctl_ff.valid || out_ready;
      for (int ch = 0; ch < sfl_pkg::NUM_CH; ch++) begin
         for (int j = 0; j < WIN; j++) begin
            prod_in[ch][j] = PROD_W'(coef[COEF_FIRST + j])
                           * PROD_W'($signed({1'b0, win[j][ch]}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   assign prod    = prod_ff;
   assign out_ctl = ctl_ff;

endmodule

// ----- rtl/sfl_sum_sat.sv -----
// Tap sum, rounding, scaling and saturation into the result register.
module sfl_sum_sat #(
   parameter int WIN  = 7,
   parameter int FRAC = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [sfl_pkg::PROD_W-1:0]    prod [sfl_pkg::NUM_CH][WIN],
   input  sfl_pkg::stage_ctl_type               in_ctl,
   output logic                                 in_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sfl_pkg::rsp_payload_type             rsp_payload
);

   localparam int ACC_W     = sfl_pkg::ACC_W;
   localparam int PIX_W     = sfl_pkg::PIX_W;
   localparam int ROUND_INT = 1 << (FRAC - 1);

   logic signed [ACC_W-1:0]          acc     [sfl_pkg::NUM_CH];
   logic signed [ACC_W-1:0]          scaled  [sfl_pkg::NUM_CH];
   logic [sfl_pkg::NUM_CH-1:0][PIX_W-1:0] pix_in;
   sfl_pkg::rsp_payload_type         out_ff, out_in;
   sfl_pkg::stage_ctl_type           ctl_ff;

   always_comb begin
      in_ready = !ctl_ff.valid || rsp_ready;
      for (int ch = 0; ch < sfl_pkg::NUM_CH; ch++) begin
         acc[ch] = ACC_W'(ROUND_INT);
         for (int j = 0; j < WIN; j++) begin
            acc[ch] = acc[ch] + ACC_W'(prod[ch][j]);
         end
         scaled[ch] = acc[ch] >>> FRAC;
         // clamp to the pixel range
         if (acc[ch][ACC_W-1]) begin
            pix_in[ch] = '0;
         end else if (scaled[ch][ACC_W-1:PIX_W] != '0) begin
            pix_in[ch] = '1;
         end else begin
            pix_in[ch] = scaled[ch][PIX_W-1:0];
         end
      end
      out_in.out_red      = pix_in[0];
      out_in.out_green    = pix_in[1];
      out_in.out_blue     = pix_in[2];
      out_in.last_of_line = in_ctl.last;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   assign rsp_valid   = ctl_ff.valid;
   assign rsp_payload = out_ff;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the seven-tap separable line filter: directed lines, then random lines.
`timescale 1ns / 100ps

module tb;

   localparam int TAP_COUNT    = 7;
   localparam int FRAC_BITS    = 14;
   localparam int HALF_RAW     = (TAP_COUNT >= 3) ? (TAP_COUNT - 1) / 2 : 1;
   localparam int HALF         = (HALF_RAW > 3) ? 3 : HALF_RAW;
   localparam int DRAIN_CYCLES = 12;
   localparam int QUIET_LIMIT  = 2000;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 13;
   localparam int NUM_ROWS     = 19;

   localparam logic MID     = 1'b0;
   localparam logic EOL     = 1'b1;
   localparam logic TYPED   = 1'b1;
   localparam logic UNTYPED = 1'b0;
   localparam sfl_pkg::rsp_payload_type NO_WANT = '0;

   typedef enum logic [sfl_pkg::CSR_IDX_W-1:0] {
      REG_COEF_M3, REG_COEF_M2, REG_COEF_M1, REG_COEF_0,
      REG_COEF_P1, REG_COEF_P2, REG_COEF_P3, REG_SPARE
   } csr_reg_type;

   typedef struct packed {
      sfl_pkg::req_payload_type px;
      logic                     typed;
      sfl_pkg::rsp_payload_type want;
   } stim_row_type;

   localparam logic signed [sfl_pkg::COEF_W-1:0] GAUSS_TAPS [sfl_pkg::NUM_COEF] = '{
      16'sd512, 16'sd1536, 16'sd3584, 16'sd5120, 16'sd3584, 16'sd1536, 16'sd512
   };

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   sfl_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   sfl_pkg::rsp_payload_type rsp_payload;
   logic                     csr_we      = 1'b0;
   logic [sfl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sfl_pkg::COEF_W-1:0]    csr_wdata = '0;

   // Filter state as the bench sees it
   logic signed [sfl_pkg::COEF_W-1:0] taps [sfl_pkg::NUM_COEF];
   sfl_pkg::pix_type                  window [sfl_pkg::NUM_COEF];
   int                                fill_count = 0;
   sfl_pkg::rsp_payload_type          blurred_q [$];

   bit                       idle_on = 1'b1;
   int                       ready_hold = 0;
   int                       quiet_cycles = 0;
   int                       mismatch_count = 0;
   sfl_pkg::rsp_payload_type seen_want;

   // Single-pixel lines under unit centre gain come straight back; longer lines follow, checked by the bench
   stim_row_type directed_rows [NUM_ROWS] = '{
      {8'h00, 8'h00, 8'h00, EOL, TYPED, 8'h00, 8'h00, 8'h00, EOL},
      {8'hff, 8'hff, 8'hff, EOL, TYPED, 8'hff, 8'hff, 8'hff, EOL},
      {8'ha5, 8'h5a, 8'h3c, EOL, TYPED, 8'ha5, 8'h5a, 8'h3c, EOL},
      {8'hff, 8'h00, 8'h80, EOL, TYPED, 8'hff, 8'h00, 8'h80, EOL},
      {8'h01, 8'h80, 8'hfe, MID, UNTYPED, NO_WANT},
      {8'h7f, 8'h00, 8'hff, EOL, UNTYPED, NO_WANT},
      {8'h10, 8'h20, 8'h30, MID, UNTYPED, NO_WANT},
      {8'h40, 8'h50, 8'h60, MID, UNTYPED, NO_WANT},
      {8'h70, 8'h80, 8'h90, EOL, UNTYPED, NO_WANT},
      {8'h00, 8'hff, 8'h00, MID, UNTYPED, NO_WANT},
      {8'hff, 8'h00, 8'hff, MID, UNTYPED, NO_WANT},
      {8'h00, 8'hff, 8'h00, MID, UNTYPED, NO_WANT},
      {8'hff, 8'h00, 8'hff, EOL, UNTYPED, NO_WANT},
      {8'h01, 8'h02, 8'h04, MID, UNTYPED, NO_WANT},
      {8'h08, 8'h10, 8'h20, MID, UNTYPED, NO_WANT},
      {8'h40, 8'h80, 8'h01, MID, UNTYPED, NO_WANT},
      {8'h02, 8'h04, 8'h08, MID, UNTYPED, NO_WANT},
      {8'h10, 8'h20, 8'h40, MID, UNTYPED, NO_WANT},
      {8'h80, 8'hff, 8'hfe, EOL, UNTYPED, NO_WANT}
   };

   separable_fir_line_filter #(
      .TAP_COUNT      (TAP_COUNT),
      .COEF_FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Weighted sum of one channel over the window, rounded half up and clamped
   function automatic logic [sfl_pkg::PIX_W-1:0] blend_channel(int ch);
      longint acc;
      acc = 0;
      for (int j = 0; j <= 2 * HALF; j++)
         acc += longint'(taps[sfl_pkg::CENTER_TAP - HALF + j])
                * longint'(window[sfl_pkg::NUM_COEF - 1 - 2 * HALF + j][ch]);
      acc += longint'(1) << (FRAC_BITS - 1);
      if (acc < 0) return '0;
      acc = acc >>> FRAC_BITS;
      if (acc > 255) return '1;
      return acc[sfl_pkg::PIX_W-1:0];
   endfunction

   function automatic void queue_blurred(logic last);
      sfl_pkg::rsp_payload_type r;
      r.out_red      = blend_channel(0);
      r.out_green    = blend_channel(1);
      r.out_blue     = blend_channel(2);
      r.last_of_line = last;
      blurred_q.push_back(r);
   endfunction

   function automatic void advance_window(sfl_pkg::pix_type pix);
      for (int k = 0; k < sfl_pkg::NUM_COEF - 1; k++) window[k] = window[k + 1];
      window[sfl_pkg::NUM_COEF - 1] = pix;
      if (fill_count < sfl_pkg::NUM_COEF) fill_count++;
   endfunction

   // Step the line filter by one pixel word; replicate the right border at end of line
   function automatic void blur_pixel(sfl_pkg::req_payload_type px);
      sfl_pkg::pix_type pix;
      pix[0] = px.in_red;
      pix[1] = px.in_green;
      pix[2] = px.in_blue;
      if (fill_count == 0) begin
         for (int k = 0; k < sfl_pkg::NUM_COEF; k++) window[k] = pix;
         fill_count = 1;
      end else begin
         advance_window(pix);
      end
      if (fill_count > HALF) queue_blurred(1'b0);
      if (px.end_of_line) begin
         for (int k = 1; k <= HALF; k++) begin
            advance_window(pix);
            if (fill_count > HALF) queue_blurred(k == HALF);
         end
         fill_count = 0;
      end
   endfunction

   function automatic logic [sfl_pkg::PIX_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return sfl_pkg::PIX_W'($urandom);
      endcase
   endfunction

   task automatic send_pixel(sfl_pkg::req_payload_type px);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (!req_ready);
      blur_pixel(px);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_reg(csr_reg_type idx, logic signed [sfl_pkg::COEF_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx != REG_SPARE) taps[int'(idx)] = val;
      @(posedge clock);
   endtask

   // Hold until every expected word is back and the border flush has settled
   task automatic wait_drained();
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side stalls in short bursts
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         ready_hold = $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (blurred_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected word: r=%h g=%h b=%h last=%b", rsp_payload.out_red,
                        rsp_payload.out_green, rsp_payload.out_blue, rsp_payload.last_of_line);
            mismatch_count++;
         end else begin
            seen_want = blurred_q.pop_front();
            if (rsp_payload.out_red !== seen_want.out_red
                || rsp_payload.out_green !== seen_want.out_green
                || rsp_payload.out_blue !== seen_want.out_blue
                || rsp_payload.last_of_line !== seen_want.last_of_line) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                           seen_want.out_red, seen_want.out_green, seen_want.out_blue,
                           seen_want.last_of_line, rsp_payload.out_red, rsp_payload.out_green,
                           rsp_payload.out_blue, rsp_payload.last_of_line);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int                                line_len;
      int                                sent;
      logic signed [sfl_pkg::COEF_W-1:0] new_taps [sfl_pkg::NUM_COEF];
      sfl_pkg::req_payload_type          px;

      for (int k = 0; k < sfl_pkg::NUM_COEF; k++) begin
         taps[k]   = sfl_pkg::COEF_RESET[k];
         window[k] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].px);
         if (directed_rows[i].typed) blurred_q[blurred_q.size() - 1] = directed_rows[i].want;
      end
      release_req();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int k = 0; k < sfl_pkg::NUM_COEF; k++) begin
            case (phase)
               0: new_taps[k] = GAUSS_TAPS[k];
               1: new_taps[k] = 16'sh7fff;
               2: new_taps[k] = 16'sh8000;
               3: new_taps[k] = (k == sfl_pkg::CENTER_TAP) ? 16'sd8192 : 16'sd0;
               4: new_taps[k] = sfl_pkg::COEF_W'($urandom);
               default: new_taps[k] = sfl_pkg::COEF_W'(int'($urandom_range(0, 12287)) - 4096);
            endcase
         end
         wait_drained();
         for (int k = 0; k < sfl_pkg::NUM_COEF; k++) write_reg(csr_reg_type'(k), new_taps[k]);
         // spare index must leave every tap alone
         if (phase == 3) write_reg(REG_SPARE, 16'sh7fff);
         @(negedge clock);
         csr_we <= 1'b0;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                   : $urandom_range(1, 8);
            idle_on  = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < line_len; k++) begin
               px.in_red      = pick_level();
               px.in_green    = pick_level();
               px.in_blue     = pick_level();
               px.end_of_line = (k == line_len - 1);
               send_pixel(px);
               sent++;
            end
         end
         release_req();
      end

      wait_drained();
      mismatch_count += blurred_q.size();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- separable_fir_line_filter.f -----
rtl/sfl_pkg.sv
rtl/sfl_window.sv
rtl/sfl_tap_mult.sv
rtl/sfl_sum_sat.sv
rtl/separable_fir_line_filter.sv
bench/tb.sv
